>>> src/assert_macros.svh
// Assertion helpers used by the datapath RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcts_pkg.sv
// ----------------------------------------------------------------------------
// tcts_pkg
// Types and constants of the three-channel tone sequencer.
// ----------------------------------------------------------------------------
package tcts_pkg;

    localparam int CHANNELS   = 3;
    localparam int RATE_MIN   = 205;
    localparam int RATE_MAX   = 32768;
    localparam int RATE_RESET = 2830;

    localparam logic [2:0] CFG_RATE  = 3'd0;
    localparam logic [2:0] CFG_LOOP  = 3'd1;
    localparam logic [2:0] CFG_TOTAL = 3'd2;
    localparam logic [2:0] CFG_CNT0  = 3'd3;
    localparam logic [2:0] CFG_CNT1  = 3'd4;
    localparam logic [2:0] CFG_CNT2  = 3'd5;

    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_PLAY     = 3'd1,
        CMD_SWITCH   = 3'd2,
        CMD_STOP     = 3'd3,
        CMD_MS       = 3'd4,
        CMD_REASSERT = 3'd5,
        CMD_STATUS   = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_TONE    = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_SILENCE = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef struct packed {
        logic  latch_in;
        logic  mem_write;
        logic  rd_first;
        logic  rd_cursor;
        logic  restart_ch;
        logic  restart_glb;
        logic  play_clr;
        logic  set_active;
        logic  clr_active;
        logic  accum;
        logic  ch_clr;
        logic  ch_inc;
        logic  ch_load;
        logic  tick_dec;
        logic  fire_a;
        logic  fire_b;
        logic  set_exh;
        logic  frame_inc;
        logic  loop_inc;
        logic  emit;
        t_kind emit_kind;
        logic  emit_last;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic ch_ok;
        logic idx_ok;
        logic active;
        logic tick;
        logic last_ch;
        logic can_fire;
        logic cur_lt;
        logic fired;
        logic later_fired;
        logic loop_due;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> src/tcts_dp.sv
// ----------------------------------------------------------------------------
// tcts_dp
// Sequencer datapath: event memory, channel state, tick accumulator,
// configuration registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcts_dp #(
    parameter int EVENTS_PER_CHANNEL = 1024,
    parameter int TICK_MS            = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic [2:0]          i_command,
    input  logic [1:0]          i_channel,
    input  logic [9:0]          i_event_index,
    input  logic [15:0]         i_frame_delta,
    input  logic [15:0]         i_tone_period,
    input  logic [7:0]          i_tone_amp,
    input  tcts_pkg::t_dp_cmd   i_cmd,
    output tcts_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_kind,
    output logic [1:0]          o_out_channel,
    output logic [15:0]         o_out_period,
    output logic [7:0]          o_out_amp,
    output logic                o_playing,
    output logic [31:0]         o_loops_done,
    output logic                o_last
);

    localparam int NCH   = tcts_pkg::CHANNELS;
    localparam int DEPTH = NCH * EVENTS_PER_CHANNEL;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(EVENTS_PER_CHANNEL + 1);
    localparam int TU    = TICK_MS * 4096;
    localparam int ACW   = $clog2(TU + tcts_pkg::RATE_MAX + 1);

    // input item
    tcts_pkg::t_cmd r_in_cmd;
    logic [1:0]     r_in_ch;
    logic [9:0]     r_in_idx;
    logic [39:0]    r_in_evt;

    // configuration
    logic [15:0] r_rate;
    logic        r_loop_en;
    logic [23:0] r_total;
    logic [10:0] r_cnt [NCH];

    // state
    logic [39:0]   r_mem [DEPTH];
    logic [39:0]   r_rdata;
    logic [CW-1:0] r_cursor [NCH];
    logic [15:0]   r_cdown [NCH];
    logic [NCH-1:0] r_exh;
    logic [NCH-1:0] r_fired;
    logic [15:0]   r_lper [NCH];
    logic [7:0]    r_lamp [NCH];
    logic [31:0]   r_frame;
    logic [31:0]   r_loops;
    logic [ACW-1:0] r_acc;
    logic          r_tick;
    logic          r_active;
    logic [1:0]    r_ch;

    logic          r_ov;
    logic [1:0]    r_okind;
    logic [1:0]    r_och;
    logic [15:0]   r_oper;
    logic [7:0]    r_oamp;
    logic          r_oplay;
    logic [31:0]   r_oloops;
    logic          r_olast;

    logic [CW-1:0]  w_cnt [NCH];
    logic [1:0]     w_cs;
    logic [15:0]    w_rate;
    logic [ACW-1:0] w_sum;
    logic [AW-1:0]  w_raddr;
    logic [AW-1:0]  w_waddr;
    logic           w_cur_lt;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            if (32'(r_cnt[c]) > 32'(EVENTS_PER_CHANNEL)) begin
                w_cnt[c] = CW'(EVENTS_PER_CHANNEL);
            end else begin
                w_cnt[c] = CW'(r_cnt[c]);
            end
        end
    end

    assign w_cs = (r_ch < 2'(NCH)) ? r_ch : 2'd0;

    always_comb begin
        if (r_rate < 16'(tcts_pkg::RATE_MIN)) begin
            w_rate = 16'(tcts_pkg::RATE_MIN);
        end else if (r_rate > 16'(tcts_pkg::RATE_MAX)) begin
            w_rate = 16'(tcts_pkg::RATE_MAX);
        end else begin
            w_rate = r_rate;
        end
    end

    assign w_sum    = r_acc + ACW'(w_rate);
    assign w_cur_lt = r_cursor[w_cs] < w_cnt[w_cs];
    assign w_raddr  = AW'(w_cs) * AW'(EVENTS_PER_CHANNEL)
                    + (i_cmd.rd_cursor ? AW'(r_cursor[w_cs]) : AW'(0));
    assign w_waddr  = AW'(r_in_ch) * AW'(EVENTS_PER_CHANNEL) + AW'(r_in_idx);

    always_comb begin
        o_sts.cmd      = r_in_cmd;
        o_sts.ch_ok    = r_in_ch < 2'(NCH);
        o_sts.idx_ok   = 32'(r_in_idx) < 32'(EVENTS_PER_CHANNEL);
        o_sts.active   = r_active;
        o_sts.tick     = r_tick;
        o_sts.last_ch  = r_ch == 2'(NCH - 1);
        o_sts.can_fire = !r_exh[w_cs] && (r_cdown[w_cs] == 16'd0) && w_cur_lt;
        o_sts.cur_lt   = w_cur_lt;
        o_sts.fired    = r_fired[w_cs];
        case (w_cs)
            2'd0:    o_sts.later_fired = r_fired[1] | r_fired[2];
            2'd1:    o_sts.later_fired = r_fired[2];
            default: o_sts.later_fired = 1'b0;
        endcase
        o_sts.loop_due = r_loop_en && (r_frame >= 32'(r_total));
        o_sts.out_busy = r_ov && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in_cmd <= tcts_pkg::t_cmd'(i_command);
            r_in_ch  <= i_channel;
            r_in_idx <= i_event_index;
            r_in_evt <= {i_tone_amp, i_tone_period, i_frame_delta};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[w_waddr] <= r_in_evt;
        end
        if (i_cmd.rd_first || i_cmd.rd_cursor) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= 16'(tcts_pkg::RATE_RESET);
            r_loop_en <= 1'b0;
            r_total   <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_cnt[c]    <= '0;
                r_cursor[c] <= '0;
                r_cdown[c]  <= '0;
                r_lper[c]   <= '0;
                r_lamp[c]   <= '0;
            end
            r_exh    <= '1;
            r_fired  <= '0;
            r_frame  <= '0;
            r_loops  <= '0;
            r_acc    <= '0;
            r_tick   <= 1'b0;
            r_active <= 1'b0;
            r_ch     <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tcts_pkg::CFG_RATE:  r_rate    <= i_cfg_data[15:0];
                    tcts_pkg::CFG_LOOP:  r_loop_en <= i_cfg_data[0];
                    tcts_pkg::CFG_TOTAL: r_total   <= i_cfg_data;
                    tcts_pkg::CFG_CNT0:  r_cnt[0]  <= i_cfg_data[10:0];
                    tcts_pkg::CFG_CNT1:  r_cnt[1]  <= i_cfg_data[10:0];
                    tcts_pkg::CFG_CNT2:  r_cnt[2]  <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_cmd.play_clr) begin
                r_loops <= '0;
                r_acc   <= '0;
            end
            if (i_cmd.set_active) r_active <= 1'b1;
            if (i_cmd.clr_active) r_active <= 1'b0;
            if (i_cmd.accum) begin
                if (32'(w_sum) >= 32'(TU)) begin
                    r_acc  <= w_sum - ACW'(TU);
                    r_tick <= 1'b1;
                end else begin
                    r_acc  <= w_sum;
                    r_tick <= 1'b0;
                end
            end
            if (i_cmd.ch_clr)  r_ch <= '0;
            if (i_cmd.ch_inc)  r_ch <= r_ch + 2'd1;
            if (i_cmd.ch_load) r_ch <= r_in_ch;
            if (i_cmd.restart_ch) begin
                r_cursor[w_cs] <= '0;
                r_cdown[w_cs]  <= (w_cnt[w_cs] != '0) ? r_rdata[15:0] : 16'd0;
                r_exh[w_cs]    <= w_cnt[w_cs] == '0;
                r_lper[w_cs]   <= '0;
                r_lamp[w_cs]   <= '0;
            end
            if (i_cmd.restart_glb) r_frame <= '0;
            if (i_cmd.tick_dec) begin
                r_fired[w_cs] <= 1'b0;
                if (!r_exh[w_cs] && r_cdown[w_cs] != 16'd0) begin
                    r_cdown[w_cs] <= r_cdown[w_cs] - 16'd1;
                end
            end
            if (i_cmd.fire_a) begin
                r_lper[w_cs]   <= r_rdata[31:16];
                r_lamp[w_cs]   <= r_rdata[39:32];
                r_fired[w_cs]  <= 1'b1;
                r_cursor[w_cs] <= r_cursor[w_cs] + CW'(1);
            end
            if (i_cmd.fire_b)    r_cdown[w_cs] <= r_rdata[15:0];
            if (i_cmd.set_exh)   r_exh[w_cs]   <= 1'b1;
            if (i_cmd.frame_inc) r_frame       <= r_frame + 32'd1;
            if (i_cmd.loop_inc)  r_loops       <= r_loops + 32'd1;
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind  <= i_cmd.emit_kind;
            r_olast  <= i_cmd.emit_last;
            r_och    <= '0;
            r_oper   <= '0;
            r_oamp   <= '0;
            r_oplay  <= 1'b0;
            r_oloops <= '0;
            case (i_cmd.emit_kind)
                tcts_pkg::KIND_TONE: begin
                    r_och  <= w_cs;
                    r_oper <= r_lper[w_cs];
                    r_oamp <= r_lamp[w_cs];
                end
                tcts_pkg::KIND_STATUS: begin
                    r_oplay  <= r_active;
                    r_oloops <= r_loops;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_kind        = r_okind;
    assign o_out_channel = r_och;
    assign o_out_period  = r_oper;
    assign o_out_amp     = r_oamp;
    assign o_playing     = r_oplay;
    assign o_loops_done  = r_oloops;
    assign o_last        = r_olast;

    `ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !(r_ov && !i_out_ready), "result overrun")
    `ASSERT_IMP(a_fire_range, i_clk, i_rst_n, i_cmd.fire_a, !r_exh[w_cs] && w_cur_lt, "fire past count")
    `ASSERT_NXT(a_tone_ch, i_clk, i_rst_n, i_cmd.emit && i_cmd.emit_kind == tcts_pkg::KIND_TONE, r_och != 2'd3, "bad tone channel")

endmodule

>>> src/tcts_ctrl.sv
// ----------------------------------------------------------------------------
// tcts_ctrl
// Sequencer controller: decodes items and steps the datapath through
// restart, tick and result phases.
// ----------------------------------------------------------------------------
module tcts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcts_pkg::t_dp_sts i_sts,
    output tcts_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RST_RD, S_RST_WR, S_EM_ENA, S_EM_SIL, S_EM_ONE,
        S_MS_CHK, S_TK_CH, S_TK_LOOP, S_TK_A, S_TK_B, S_TK_C, S_TK_FR,
        S_TK_EM, S_TK_LP
    } t_state;

    typedef enum logic [1:0] {CTX_PLAY, CTX_SWITCH, CTX_LOOP} t_ctx;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    tcts_pkg::t_kind r_kind, n_kind;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        n_kind  = r_kind;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (i_sts.cmd)
                    tcts_pkg::CMD_LOAD: begin
                        o_cmd.mem_write = i_sts.ch_ok && i_sts.idx_ok;
                    end
                    tcts_pkg::CMD_PLAY: begin
                        o_cmd.play_clr   = 1'b1;
                        o_cmd.set_active = 1'b1;
                        o_cmd.ch_clr     = 1'b1;
                        n_ctx   = CTX_PLAY;
                        n_state = S_RST_RD;
                    end
                    tcts_pkg::CMD_SWITCH: begin
                        o_cmd.set_active = 1'b1;
                        o_cmd.ch_clr     = 1'b1;
                        n_ctx   = CTX_SWITCH;
                        n_state = S_RST_RD;
                    end
                    tcts_pkg::CMD_STOP: begin
                        o_cmd.clr_active = 1'b1;
                        n_kind  = tcts_pkg::KIND_SILENCE;
                        n_state = S_EM_ONE;
                    end
                    tcts_pkg::CMD_MS: begin
                        if (i_sts.active) begin
                            o_cmd.accum = 1'b1;
                            n_state = S_MS_CHK;
                        end
                    end
                    tcts_pkg::CMD_REASSERT: begin
                        if (i_sts.active && i_sts.ch_ok) begin
                            o_cmd.ch_load = 1'b1;
                            n_kind  = tcts_pkg::KIND_TONE;
                            n_state = S_EM_ONE;
                        end
                    end
                    tcts_pkg::CMD_STATUS: begin
                        n_kind  = tcts_pkg::KIND_STATUS;
                        n_state = S_EM_ONE;
                    end
                    default: ;
                endcase
            end
            S_RST_RD: begin
                o_cmd.rd_first = 1'b1;
                n_state = S_RST_WR;
            end
            S_RST_WR: begin
                o_cmd.restart_ch = 1'b1;
                if (i_sts.last_ch) begin
                    o_cmd.restart_glb = 1'b1;
                    n_state = (r_ctx == CTX_PLAY) ? S_EM_ENA : S_IDLE;
                end else begin
                    o_cmd.ch_inc = 1'b1;
                    n_state = S_RST_RD;
                end
            end
            S_EM_ENA: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = tcts_pkg::KIND_ENABLE;
                    n_state = S_EM_SIL;
                end
            end
            S_EM_SIL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = tcts_pkg::KIND_SILENCE;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EM_ONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_kind;
                    o_cmd.emit_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MS_CHK: begin
                if (i_sts.tick) begin
                    o_cmd.ch_clr = 1'b1;
                    n_state = S_TK_CH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TK_CH: begin
                o_cmd.tick_dec = 1'b1;
                n_state = S_TK_LOOP;
            end
            S_TK_LOOP: begin
                if (i_sts.can_fire) begin
                    o_cmd.rd_cursor = 1'b1;
                    n_state = S_TK_A;
                end else if (i_sts.last_ch) begin
                    n_state = S_TK_FR;
                end else begin
                    o_cmd.ch_inc = 1'b1;
                    n_state = S_TK_CH;
                end
            end
            S_TK_A: begin
                o_cmd.fire_a = 1'b1;
                n_state = S_TK_B;
            end
            S_TK_B: begin
                if (i_sts.cur_lt) begin
                    o_cmd.rd_cursor = 1'b1;
                    n_state = S_TK_C;
                end else begin
                    o_cmd.set_exh = 1'b1;
                    n_state = S_TK_LOOP;
                end
            end
            S_TK_C: begin
                o_cmd.fire_b = 1'b1;
                n_state = S_TK_LOOP;
            end
            S_TK_FR: begin
                o_cmd.frame_inc = 1'b1;
                o_cmd.ch_clr    = 1'b1;
                n_state = S_TK_EM;
            end
            S_TK_EM: begin
                if (!i_sts.fired || !i_sts.out_busy) begin
                    if (i_sts.fired) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = tcts_pkg::KIND_TONE;
                        o_cmd.emit_last = !i_sts.later_fired;
                    end
                    if (i_sts.last_ch) begin
                        n_state = S_TK_LP;
                    end else begin
                        o_cmd.ch_inc = 1'b1;
                    end
                end
            end
            S_TK_LP: begin
                if (i_sts.loop_due) begin
                    o_cmd.loop_inc = 1'b1;
                    o_cmd.ch_clr   = 1'b1;
                    n_ctx   = CTX_LOOP;
                    n_state = S_RST_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ctx      <= CTX_PLAY;
            r_kind     <= tcts_pkg::KIND_TONE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ctx      <= n_ctx;
            r_kind     <= n_kind;
            r_in_ready <= n_state == S_IDLE;
        end
    end

    assign o_in_ready = r_in_ready && (r_state == S_IDLE);

endmodule

>>> src/three_channel_tone_sequencer_core.sv
// A millisecond item adds the rate to the tick accumulator; a tick then steps every
// channel and reads the event memory for each fired event, and a loop restart reads
// each channel's first event again. Results can stall on the receiver.
// One item is in work at a time.
// Reset: synchronous, active low; the event memory is not cleared.
// ----------------------------------------------------------------------------
// three_channel_tone_sequencer_core
// Three-channel tone sequencer with per-channel event memory and loop control.
// ----------------------------------------------------------------------------
module three_channel_tone_sequencer_core #(
    parameter int EVENTS_PER_CHANNEL = 1024,
    parameter int TICK_MS            = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [1:0]  i_channel,
    input  logic [9:0]  i_event_index,
    input  logic [15:0] i_frame_delta,
    input  logic [15:0] i_tone_period,
    input  logic [7:0]  i_tone_amp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_out_channel,
    output logic [15:0] o_out_period,
    output logic [7:0]  o_out_amp,
    output logic        o_playing,
    output logic [31:0] o_loops_done,
    output logic        o_last
);

    tcts_pkg::t_dp_cmd w_cmd;
    tcts_pkg::t_dp_sts w_sts;

    tcts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcts_dp #(
        .EVENTS_PER_CHANNEL (EVENTS_PER_CHANNEL),
        .TICK_MS            (TICK_MS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_event_index (i_event_index),
        .i_frame_delta (i_frame_delta),
        .i_tone_period (i_tone_period),
        .i_tone_amp    (i_tone_amp),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_channel (o_out_channel),
        .o_out_period  (o_out_period),
        .o_out_amp     (o_out_amp),
        .o_playing     (o_playing),
        .o_loops_done  (o_loops_done),
        .o_last        (o_last)
    );

endmodule

>>> tb/three_channel_tone_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_tone_sequencer_core_tb
// Self-checking bench: a queue-fed driver plays commands into the sequencer.
// Each accepted item runs through a local behavioral copy of the sequencer
// and the predicted sound-chip writes are checked field by field.
// ----------------------------------------------------------------------------
module three_channel_tone_sequencer_core_tb;

    localparam int          EPC       = 1024;
    localparam int          LOADED    = 16;
    localparam int          TICK_UNIT = 20 * 4096;
    localparam logic [2:0]  CMD_BAD   = 3'd7;
    localparam int          LIMIT     = 2000000;

    typedef struct {
        logic [2:0]  cmd;
        logic [1:0]  ch;
        logic [9:0]  idx;
        logic [15:0] delta;
        logic [15:0] period;
        logic [7:0]  amp;
    } t_item;

    typedef struct {
        tcts_pkg::t_kind kind;
        logic [1:0]  ch;
        logic [15:0] period;
        logic [7:0]  amp;
        logic        playing;
        logic [31:0] loops;
        logic        last;
    } t_write;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_in_valid, o_in_ready;
    logic [2:0]  i_command;
    logic [1:0]  i_channel;
    logic [9:0]  i_event_index;
    logic [15:0] i_frame_delta, i_tone_period;
    logic [7:0]  i_tone_amp;
    logic        o_out_valid, i_out_ready;
    logic [1:0]  o_kind, o_out_channel;
    logic [15:0] o_out_period;
    logic [7:0]  o_out_amp;
    logic        o_playing;
    logic [31:0] o_loops_done;
    logic        o_last;

    three_channel_tone_sequencer_core DUT (.*);

    // sequencer state as predicted
    logic [39:0] song_mem [0:3*EPC-1];
    int          ev_pos [3];
    logic [15:0] ev_wait [3];
    bit          ch_done [3];
    logic [15:0] held_period [3];
    logic [7:0]  held_amp [3];
    logic [31:0] frames, loops;
    int          accum;
    bit          running;
    logic [15:0] rate;
    bit          loop_en;
    logic [23:0] total;
    logic [10:0] ev_count [3];

    t_item  pending_q [$];
    t_write chip_write_q [$];
    t_item  cur;
    int     in_gap, out_gap, cycles, errors, n_items, n_writes, n_ticks;
    bit     idle_on;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int eff_count(int c);
        return (ev_count[c] > EPC) ? EPC : int'(ev_count[c]);
    endfunction

    function automatic void add_write(tcts_pkg::t_kind k, int c, logic [15:0] p,
                                      logic [7:0] a, logic pl, logic [31:0] lc);
        t_write w;
        w.kind = k; w.ch = c[1:0]; w.period = p; w.amp = a;
        w.playing = pl; w.loops = lc; w.last = 0;
        chip_write_q.push_back(w);
    endfunction

    function automatic void restart_song();
        for (int c = 0; c < 3; c++) begin
            ev_pos[c] = 0;
            if (eff_count(c) > 0) begin
                ev_wait[c] = song_mem[c*EPC][15:0];
                ch_done[c] = 0;
            end else begin
                ev_wait[c] = 0;
                ch_done[c] = 1;
            end
            held_period[c] = 0;
            held_amp[c] = 0;
        end
        frames = 0;
    endfunction

    function automatic void run_frame();
        int  cnt;
        bit  fired;
        logic [39:0] e;
        n_ticks++;
        for (int c = 0; c < 3; c++) begin
            cnt = eff_count(c);
            fired = 0;
            if (!ch_done[c]) begin
                if (ev_wait[c] > 0) ev_wait[c]--;
                while (!ch_done[c] && ev_wait[c] == 0 && ev_pos[c] < cnt) begin
                    e = song_mem[c*EPC + ev_pos[c]];
                    held_period[c] = e[31:16];
                    held_amp[c] = e[39:32];
                    fired = 1;
                    ev_pos[c]++;
                    if (ev_pos[c] < cnt) ev_wait[c] = song_mem[c*EPC + ev_pos[c]][15:0];
                    else ch_done[c] = 1;
                end
                if (fired)
                    add_write(tcts_pkg::KIND_TONE, c, held_period[c], held_amp[c], 0, 0);
            end
        end
        frames++;
        if (loop_en && frames >= {8'd0, total}) begin
            loops++;
            restart_song();
        end
    endfunction

    function automatic void predict_writes(t_item it);
        int n_prev, r;
        n_prev = chip_write_q.size();
        case (it.cmd)
            tcts_pkg::CMD_LOAD:
                if (it.ch < 3)
                    song_mem[int'(it.ch)*EPC + int'(it.idx)] = {it.amp, it.period, it.delta};
            tcts_pkg::CMD_PLAY: begin
                restart_song();
                loops = 0;
                accum = 0;
                running = 1;
                add_write(tcts_pkg::KIND_ENABLE, 0, 0, 0, 0, 0);
                add_write(tcts_pkg::KIND_SILENCE, 0, 0, 0, 0, 0);
            end
            tcts_pkg::CMD_SWITCH: begin
                restart_song();
                running = 1;
            end
            tcts_pkg::CMD_STOP: begin
                running = 0;
                add_write(tcts_pkg::KIND_SILENCE, 0, 0, 0, 0, 0);
            end
            tcts_pkg::CMD_MS:
                if (running) begin
                    r = int'(rate);
                    if (r < tcts_pkg::RATE_MIN) r = tcts_pkg::RATE_MIN;
                    if (r > tcts_pkg::RATE_MAX) r = tcts_pkg::RATE_MAX;
                    accum += r;
                    if (accum >= TICK_UNIT) begin
                        accum -= TICK_UNIT;
                        run_frame();
                    end
                end
            tcts_pkg::CMD_REASSERT:
                if (running && it.ch < 3)
                    add_write(tcts_pkg::KIND_TONE, int'(it.ch), held_period[it.ch],
                              held_amp[it.ch], 0, 0);
            tcts_pkg::CMD_STATUS: add_write(tcts_pkg::KIND_STATUS, 0, 0, 0, running, loops);
            default: ;
        endcase
        if (chip_write_q.size() > n_prev) chip_write_q[chip_write_q.size()-1].last = 1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_writes(cur);
                n_items++;
                if (idle_on && $urandom_range(3) == 0) in_gap = $urandom_range(1, 7);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 0;
                end else if (pending_q.size() > 0) begin
                    cur = pending_q.pop_front();
                    i_command <= cur.cmd;
                    i_channel <= cur.ch;
                    i_event_index <= cur.idx;
                    i_frame_delta <= cur.delta;
                    i_tone_period <= cur.period;
                    i_tone_amp <= cur.amp;
                    i_in_valid <= 1;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
            if (idle_on && $urandom_range(5) == 0) out_gap = $urandom_range(1, 7);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_write w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_writes++;
            if (chip_write_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result kind=%0d", o_kind);
            end else begin
                w = chip_write_q.pop_front();
                if (o_kind !== w.kind || o_out_channel !== w.ch
                    || o_out_period !== w.period || o_out_amp !== w.amp
                    || o_playing !== w.playing || o_loops_done !== w.loops
                    || o_last !== w.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("ERROR: exp k=%0d ch=%0d p=%h a=%h pl=%b lp=%0d l=%b",
                                 w.kind, w.ch, w.period, w.amp, w.playing, w.loops,
                                 w.last);
                        $display("       got k=%0d ch=%0d p=%h a=%h pl=%b lp=%0d l=%b",
                                 o_kind, o_out_channel, o_out_period, o_out_amp,
                                 o_playing, o_loops_done, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_cmd(logic [2:0] cmd, logic [1:0] ch = 0);
        t_item it;
        it.cmd = cmd; it.ch = ch; it.idx = 10'($urandom); it.delta = 16'($urandom);
        it.period = 16'($urandom); it.amp = 8'($urandom);
        pending_q.push_back(it);
    endtask

    task automatic push_load(logic [1:0] ch, logic [9:0] idx, logic [15:0] d);
        t_item it;
        it.cmd = tcts_pkg::CMD_LOAD; it.ch = ch; it.idx = idx; it.delta = d;
        it.period = 16'($urandom); it.amp = 8'($urandom);
        pending_q.push_back(it);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            tcts_pkg::CFG_RATE:  rate = data[15:0];
            tcts_pkg::CFG_LOOP:  loop_en = data[0];
            tcts_pkg::CFG_TOTAL: total = data;
            tcts_pkg::CFG_CNT0:  ev_count[0] = data[10:0];
            tcts_pkg::CFG_CNT1:  ev_count[1] = data[10:0];
            tcts_pkg::CFG_CNT2:  ev_count[2] = data[10:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (pending_q.size() > 0 || i_in_valid || chip_write_q.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_delta();
        int r;
        r = $urandom_range(15);
        if (r < 5) return 0;
        if (r == 15) return 16'hFFFF;
        return 16'($urandom_range(1, 3));
    endfunction

    function automatic logic [23:0] rand_count();
        case ($urandom_range(5))
            0: return 0;
            1: return 1;
            2: return 1024;
            3: return 2047;
            default: return 24'($urandom_range(2, 40));
        endcase
    endfunction

    initial begin
        int r;
        i_clk = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        i_in_valid = 0; i_out_ready = 0; i_command = 0; i_channel = 0;
        i_event_index = 0; i_frame_delta = 0; i_tone_period = 0; i_tone_amp = 0;
        for (int k = 0; k < 3*EPC; k++) song_mem[k] = 0;
        for (int c = 0; c < 3; c++) begin
            ev_pos[c] = 0; ev_wait[c] = 0; ch_done[c] = 1;
            held_period[c] = 0; held_amp[c] = 0; ev_count[c] = 0;
        end
        frames = 0; loops = 0; accum = 0; running = 0;
        rate = 16'(tcts_pkg::RATE_RESET); loop_en = 0; total = 0;
        errors = 0; cycles = 0; n_items = 0; n_writes = 0; n_ticks = 0;
        in_gap = 0; out_gap = 0; idle_on = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // idle commands before any song, bad channel, unknown command
        push_cmd(tcts_pkg::CMD_STATUS);
        push_cmd(tcts_pkg::CMD_REASSERT, 1);
        push_cmd(tcts_pkg::CMD_MS);
        push_cmd(tcts_pkg::CMD_STOP);
        push_cmd(CMD_BAD);
        push_load(3, 10'h3FF, 16'hFFFF);
        // the top loaded slot never comes due, so playback stays on loaded slots
        for (int k = 0; k < 3*LOADED; k++)
            push_load(2'(k / LOADED), 10'(k % LOADED),
                      (k % LOADED == LOADED - 1) ? 16'hFFFF : rand_delta());
        settle();

        cfg_write(tcts_pkg::CFG_RATE, 24'd32768);
        cfg_write(tcts_pkg::CFG_LOOP, 24'd1);
        cfg_write(tcts_pkg::CFG_TOTAL, 24'd5);
        cfg_write(tcts_pkg::CFG_CNT0, 24'd3);
        cfg_write(tcts_pkg::CFG_CNT1, 24'd0);
        cfg_write(tcts_pkg::CFG_CNT2, 24'd2047);
        push_cmd(tcts_pkg::CMD_PLAY);
        repeat (12) push_cmd(tcts_pkg::CMD_MS);
        for (int c = 0; c < 4; c++) push_cmd(tcts_pkg::CMD_REASSERT, 2'(c));
        push_cmd(tcts_pkg::CMD_STATUS);
        push_cmd(tcts_pkg::CMD_SWITCH);
        repeat (3) push_cmd(tcts_pkg::CMD_MS);
        push_cmd(tcts_pkg::CMD_STOP);
        push_cmd(tcts_pkg::CMD_STATUS);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 6) idle_on = 0;
            case (ph % 4)
                0: cfg_write(tcts_pkg::CFG_RATE, 24'd0);
                1: cfg_write(tcts_pkg::CFG_RATE, 24'd65535);
                2: cfg_write(tcts_pkg::CFG_RATE, 24'd205);
                default: cfg_write(tcts_pkg::CFG_RATE, 24'($urandom_range(8000, 32768)));
            endcase
            if (ph % 4 == 2) cfg_write(tcts_pkg::CFG_RATE, 24'd32768);
            cfg_write(tcts_pkg::CFG_LOOP, 24'($urandom_range(1)));
            r = $urandom_range(3);
            cfg_write(tcts_pkg::CFG_TOTAL, r == 0 ? 24'd0 : r == 1 ? 24'hFFFFFF
                                                 : 24'($urandom_range(1, 12)));
            cfg_write(tcts_pkg::CFG_CNT0, rand_count());
            cfg_write(tcts_pkg::CFG_CNT1, rand_count());
            cfg_write(tcts_pkg::CFG_CNT2, rand_count());
            if ($urandom_range(2) != 0) push_cmd(tcts_pkg::CMD_PLAY);
            else if ($urandom_range(1)) push_cmd(tcts_pkg::CMD_SWITCH);
            for (int k = 0; k < 14; k++) begin
                r = $urandom_range(19);
                if (r < 13) push_cmd(tcts_pkg::CMD_MS);
                else if (r < 15) push_cmd(tcts_pkg::CMD_REASSERT, 2'($urandom_range(3)));
                else if (r == 15) push_cmd(tcts_pkg::CMD_STATUS);
                else if (r == 16)
                    push_load(2'($urandom_range(3)), 10'($urandom_range(LOADED - 2)),
                              rand_delta());
                else if (r == 17)
                    push_cmd($urandom_range(1) ? tcts_pkg::CMD_SWITCH : CMD_BAD);
                else if (r == 18) push_cmd(tcts_pkg::CMD_PLAY);
                else push_cmd(tcts_pkg::CMD_STOP, 2'($urandom));
            end
            push_cmd(tcts_pkg::CMD_STATUS);
            settle();
        end

        $display("Run covered %0d items, %0d chip writes, %0d playback ticks",
                 n_items, n_writes, n_ticks);
        $display("across clamped rates, looping, chords and lowered event counts");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/tcts_pkg.sv
src/tcts_dp.sv
src/tcts_ctrl.sv
src/three_channel_tone_sequencer_core.sv
tb/three_channel_tone_sequencer_core_tb.sv
